FILE: hdl/matrix_to_quaternion_unit_assert.svh
// assertion macros for the matrix to quaternion unit checker
// no dependencies; the including module supplies clock and reset
`ifndef MATRIX_TO_QUATERNION_UNIT_ASSERT_SVH
`define MATRIX_TO_QUATERNION_UNIT_ASSERT_SVH

// same-cycle implication, off during reset
`define MQ_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, off during reset
`define MQ_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

// next-cycle implication that also holds across reset
`define MQ_ASSERT_ALWAYS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: hdl/mq_pkg.sv
// shared widths, payload structs and cell data types for the matrix to quaternion unit
// no dependencies
package mq_pkg;

   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = 14;

   // magnitude of a sum or difference of two entries
   localparam int MAG_W    = DATA_WIDTH + 1;
   // positive radicand
   localparam int RAD_W    = DATA_WIDTH + 1;
   // square root of radicand scaled by the fraction
   localparam int ROOT_W   = (RAD_W + FRAC_BITS + 1) / 2;
   localparam int SQ_IN_W  = 2 * ROOT_W;
   localparam int SQ_REM_W = ROOT_W + 3;
   // divider numerator, divisor and partial remainder
   localparam int NUM_W    = MAG_W + FRAC_BITS + 1;
   localparam int DIV_W    = ROOT_W + 1;
   localparam int DREM_W   = DIV_W + 1;

   localparam logic signed [DATA_WIDTH-1:0] ONE_Q = DATA_WIDTH'(1 << FRAC_BITS);

   // which component takes r/2
   typedef enum logic [1:0] {PICK_TRACE, PICK_X, PICK_Y, PICK_Z} pick_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] m00;
      logic signed [DATA_WIDTH-1:0] m01;
      logic signed [DATA_WIDTH-1:0] m02;
      logic signed [DATA_WIDTH-1:0] m10;
      logic signed [DATA_WIDTH-1:0] m11;
      logic signed [DATA_WIDTH-1:0] m12;
      logic signed [DATA_WIDTH-1:0] m20;
      logic signed [DATA_WIDTH-1:0] m21;
      logic signed [DATA_WIDTH-1:0] m22;
   } mq_req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] quat_w;
      logic signed [DATA_WIDTH-1:0] quat_x;
      logic signed [DATA_WIDTH-1:0] quat_y;
      logic signed [DATA_WIDTH-1:0] quat_z;
      logic                         degenerate;
   } mq_rsp_type;

   // travels unchanged along both chains
   typedef struct packed {
      logic [2:0]            neg;
      logic [2:0][MAG_W-1:0] mag;
      pick_type              pick;
      logic                  degenerate;
   } side_type;

   typedef struct packed {
      logic [SQ_IN_W-1:0]  rad;
      logic [SQ_REM_W-1:0] rem;
      logic [ROOT_W-1:0]   root;
      side_type            side;
   } sq_type;

   typedef struct packed {
      logic [2:0][NUM_W-1:0]  num;
      logic [2:0][DREM_W-1:0] rem;
      logic [DIV_W-1:0]       divisor;
      logic [ROOT_W-1:0]      root;
      side_type               side;
   } dv_type;

endpackage

FILE: hdl/mq_sqrt_cell.sv
// one digit step of the pipelined integer square root
// depends on mq_pkg
module mq_sqrt_cell import mq_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   in_valid,
   input  sq_type in_data,
   output logic   in_ready,
   output logic   out_valid,
   output sq_type out_data,
   input  logic   out_ready
);

   logic   valid_ff, valid_in;
   sq_type data_ff, data_in;
   logic [SQ_REM_W-1:0] rem2, trial;

   assign in_ready = !valid_ff || out_ready;

   // bring down two radicand bits and try the next root bit
   always_comb begin
      rem2  = {in_data.rem[SQ_REM_W-3:0], in_data.rad[SQ_IN_W-1 -: 2]};
      trial = SQ_REM_W'({in_data.root, 2'b01});
      data_in      = in_data;
      data_in.rad  = {in_data.rad[SQ_IN_W-3:0], 2'b00};
      if (rem2 >= trial) begin
         data_in.rem  = rem2 - trial;
         data_in.root = {in_data.root[ROOT_W-2:0], 1'b1};
      end else begin
         data_in.rem  = rem2;
         data_in.root = {in_data.root[ROOT_W-2:0], 1'b0};
      end
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: hdl/mq_div_cell.sv
// one quotient bit of the three pipelined dividers
// depends on mq_pkg
module mq_div_cell import mq_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   in_valid,
   input  dv_type in_data,
   output logic   in_ready,
   output logic   out_valid,
   output dv_type out_data,
   input  logic   out_ready
);

   logic   valid_ff, valid_in;
   dv_type data_ff, data_in;
   logic [DREM_W-1:0] rem2;
   logic [DREM_W-1:0] div_ext;

   assign in_ready = !valid_ff || out_ready;

   // restoring step per lane, quotient bits shift in behind the numerator
   always_comb begin
      data_in = in_data;
      div_ext = DREM_W'(in_data.divisor);
      rem2    = '0;
      for (int l = 0; l < 3; l++) begin
         rem2 = {in_data.rem[l][DREM_W-2:0], in_data.num[l][NUM_W-1]};
         if (rem2 >= div_ext) begin
            data_in.rem[l] = rem2 - div_ext;
            data_in.num[l] = {in_data.num[l][NUM_W-2:0], 1'b1};
         end else begin
            data_in.rem[l] = rem2;
            data_in.num[l] = {in_data.num[l][NUM_W-2:0], 1'b0};
         end
      end
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: hdl/matrix_to_quaternion_unit.sv
// top level: rotation matrix to quaternion by Shepperd's method
// depends on mq_pkg, mq_sqrt_cell and mq_div_cell
//
// Takes one matrix request per clock while req_stall is low and returns its
// quaternion through one input register, a chain of ROOT_W (16) square-root
// cells, a chain of NUM_W (32) divider cells each serving the three off-axis
// parts at once, and the output register. Every cell holds its item while the
// next one is full, so a stalled output only stops the stages behind it once
// they fill and empty stages keep taking requests. A non-positive radicand
// returns the identity quaternion with degenerate set.
module matrix_to_quaternion_unit import mq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  mq_req_type req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output mq_rsp_type rsp_data
);

   localparam int SW = DATA_WIDTH + 3;

   logic   front_valid_ff, front_ready;
   sq_type front_ff, front_in;

   logic   sq_v [ROOT_W+1];
   logic   sq_r [ROOT_W+1];
   sq_type sq_d [ROOT_W+1];
   logic   dv_v [NUM_W+1];
   logic   dv_r [NUM_W+1];
   dv_type dv_d [NUM_W+1];

   logic       rsp_valid_ff, back_ready;
   mq_rsp_type rsp_ff, rsp_in;

   // case choice, radicand and the three signed lane values
   always_comb begin
      logic signed [SW-1:0] m [3][3];
      logic signed [SW-1:0] trace, rad;
      logic signed [SW-1:0] d [3];
      logic [1:0] i, j, k;
      m[0][0] = SW'(req_data.m00); m[0][1] = SW'(req_data.m01);
      m[0][2] = SW'(req_data.m02); m[1][0] = SW'(req_data.m10);
      m[1][1] = SW'(req_data.m11); m[1][2] = SW'(req_data.m12);
      m[2][0] = SW'(req_data.m20); m[2][1] = SW'(req_data.m21);
      m[2][2] = SW'(req_data.m22);
      trace = m[0][0] + m[1][1] + m[2][2];
      i = 2'd0;
      if (m[1][1] > m[0][0]) i = 2'd1;
      if (m[2][2] > m[i][i]) i = 2'd2;
      j = (i == 2'd2) ? 2'd0 : i + 2'd1;
      k = (j == 2'd2) ? 2'd0 : j + 2'd1;
      front_in = '0;
      if (trace > 0) begin
         rad  = trace + SW'(ONE_Q);
         d[0] = m[1][2] - m[2][1];
         d[1] = m[2][0] - m[0][2];
         d[2] = m[0][1] - m[1][0];
         front_in.side.pick = PICK_TRACE;
      end else begin
         rad  = m[i][i] - m[j][j] - m[k][k] + SW'(ONE_Q);
         d[0] = m[j][k] - m[k][j];
         d[1] = m[i][j] + m[j][i];
         d[2] = m[i][k] + m[k][i];
         case (i)
            2'd0:    front_in.side.pick = PICK_X;
            2'd1:    front_in.side.pick = PICK_Y;
            default: front_in.side.pick = PICK_Z;
         endcase
      end
      front_in.side.degenerate = (rad <= 0);
      // degenerate items run with a radicand of one and are overridden at the end
      if (rad <= 0) rad = SW'(1);
      front_in.rad = SQ_IN_W'(rad[RAD_W-1:0]) << FRAC_BITS;
      for (int l = 0; l < 3; l++) begin
         front_in.side.neg[l] = d[l][SW-1];
         front_in.side.mag[l] = d[l][SW-1] ? MAG_W'(-d[l]) : MAG_W'(d[l]);
      end
   end

   // input register
   assign front_ready = !front_valid_ff || sq_r[0];
   assign req_stall   = !front_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else if (front_ready) begin
         front_valid_ff <= req_valid;
      end
      if (front_ready && req_valid) begin
         front_ff <= front_in;
      end
   end

   assign sq_v[0] = front_valid_ff;
   assign sq_d[0] = front_ff;

   // square-root chain
   for (genvar c = 0; c < ROOT_W; c++) begin : g_sq
      mq_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sq_v[c]),
         .in_data   (sq_d[c]),
         .in_ready  (sq_r[c]),
         .out_valid (sq_v[c+1]),
         .out_data  (sq_d[c+1]),
         .out_ready (sq_r[c+1])
      );
   end

   // numerators |d| * 2^F + R over divisor 2R, rounding half away from zero
   always_comb begin
      dv_d[0]         = '0;
      dv_d[0].divisor = {sq_d[ROOT_W].root, 1'b0};
      dv_d[0].root    = sq_d[ROOT_W].root;
      dv_d[0].side    = sq_d[ROOT_W].side;
      for (int l = 0; l < 3; l++) begin
         dv_d[0].num[l] = (NUM_W'(sq_d[ROOT_W].side.mag[l]) << FRAC_BITS)
                          + NUM_W'(sq_d[ROOT_W].root);
      end
   end
   assign dv_v[0]      = sq_v[ROOT_W];
   assign sq_r[ROOT_W] = dv_r[0];

   // divider chain
   for (genvar c = 0; c < NUM_W; c++) begin : g_dv
      mq_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (dv_v[c]),
         .in_data   (dv_d[c]),
         .in_ready  (dv_r[c]),
         .out_valid (dv_v[c+1]),
         .out_data  (dv_d[c+1]),
         .out_ready (dv_r[c+1])
      );
   end

   function automatic logic signed [DATA_WIDTH-1:0] sat_q(logic neg, logic [NUM_W-1:0] mag);
      logic [NUM_W-1:0] max_pos, max_neg;
      max_pos = NUM_W'((1 << (DATA_WIDTH - 1)) - 1);
      max_neg = NUM_W'(1 << (DATA_WIDTH - 1));
      if (!neg) begin
         sat_q = (mag > max_pos) ? DATA_WIDTH'(max_pos) : DATA_WIDTH'(mag);
      end else begin
         sat_q = (mag > max_neg) ? DATA_WIDTH'(max_neg) : DATA_WIDTH'(-mag);
      end
   endfunction

   // place r/2 and the three quotients, saturate
   always_comb begin
      logic signed [DATA_WIDTH-1:0] half, l0, l1, l2;
      logic [ROOT_W:0] half_u;
      half_u = ({1'b0, dv_d[NUM_W].root} + 1'b1) >> 1;
      half   = sat_q(1'b0, NUM_W'(half_u));
      l0     = sat_q(dv_d[NUM_W].side.neg[0], dv_d[NUM_W].num[0]);
      l1     = sat_q(dv_d[NUM_W].side.neg[1], dv_d[NUM_W].num[1]);
      l2     = sat_q(dv_d[NUM_W].side.neg[2], dv_d[NUM_W].num[2]);
      rsp_in = '0;
      case (dv_d[NUM_W].side.pick)
         PICK_TRACE: begin
            rsp_in.quat_w = half; rsp_in.quat_x = l0;
            rsp_in.quat_y = l1;   rsp_in.quat_z = l2;
         end
         PICK_X: begin
            rsp_in.quat_x = half; rsp_in.quat_w = l0;
            rsp_in.quat_y = l1;   rsp_in.quat_z = l2;
         end
         PICK_Y: begin
            rsp_in.quat_y = half; rsp_in.quat_w = l0;
            rsp_in.quat_z = l1;   rsp_in.quat_x = l2;
         end
         default: begin
            rsp_in.quat_z = half; rsp_in.quat_w = l0;
            rsp_in.quat_x = l1;   rsp_in.quat_y = l2;
         end
      endcase
      if (dv_d[NUM_W].side.degenerate) begin
         rsp_in.quat_w     = ONE_Q;
         rsp_in.quat_x     = '0;
         rsp_in.quat_y     = '0;
         rsp_in.quat_z     = '0;
         rsp_in.degenerate = 1'b1;
      end
   end

   // output register
   assign back_ready   = !rsp_valid_ff || !rsp_stall;
   assign dv_r[NUM_W]  = back_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (back_ready) begin
         rsp_valid_ff <= dv_v[NUM_W];
      end
      if (back_ready && dv_v[NUM_W]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: hdl/mq_checker.sv
// port-level checks for the matrix to quaternion unit, bound to the top level
// depends on mq_pkg and matrix_to_quaternion_unit_assert.svh
`include "matrix_to_quaternion_unit_assert.svh"

module mq_checker import mq_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input mq_req_type req_data,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input mq_rsp_type rsp_data
);

   // a held result keeps its value
   `MQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // degenerate results are the identity quaternion
   `MQ_ASSERT_NOW(a_identity, rsp_valid && rsp_data.degenerate, rsp_data.quat_w == ONE_Q && rsp_data.quat_x == '0 && rsp_data.quat_y == '0 && rsp_data.quat_z == '0)

   // an empty output register means every cell can move
   `MQ_ASSERT_NOW(a_no_false_stall, !rsp_valid, !req_stall)

   // nothing comes out straight after reset
   `MQ_ASSERT_ALWAYS(a_reset_empty, reset, !rsp_valid)

endmodule

bind matrix_to_quaternion_unit mq_checker u_mq_checker (.*);
